// ===== rtl/carrier_smoothed_range_filter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the carrier smoothed range filter
// Short forms for concurrent checks on clk with the asynchronous reset masked.
// ----------------------------------------------------------------------------
`ifndef CARRIER_SMOOTHED_RANGE_FILTER_CORE_ASSERT_SVH
`define CARRIER_SMOOTHED_RANGE_FILTER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CSRF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CSRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/csrf_pkg.sv =====
// ----------------------------------------------------------------------------
// csrf_pkg
// Shared widths, codes and types of the carrier smoothed range filter.
// ----------------------------------------------------------------------------
package csrf_pkg;

	// request field widths
	localparam int SAT_INDEX_W = 6;
	localparam int RANGE_W     = 40;
	localparam int PHASE_W     = 48;
	localparam int EPOCH_W     = 32;
	localparam int REASON_W    = 3;

	// configuration registers
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 24;
	localparam int INTERVAL_W  = 24;
	localparam int TOL_W       = 10;
	localparam int AGE_W       = 24;
	localparam int SLIP_W      = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_EPOCH_INTERVAL  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EPOCH_TOLERANCE = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_AGE         = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SLIP_THRESHOLD  = 4'd3;

	localparam logic [INTERVAL_W-1:0] EPOCH_INTERVAL_RST  = 24'd3000;
	localparam logic [TOL_W-1:0]      EPOCH_TOLERANCE_RST = 10'd10;
	localparam logic [AGE_W-1:0]      MAX_AGE_RST         = 24'd8640000;
	localparam logic [SLIP_W-1:0]     SLIP_THRESHOLD_RST  = 20'd20480;

	// default sizing
	localparam int NUM_SATS_DEF = 64;
	localparam int WINDOW_K_DEF = 10;

	// divide-by-K datapath; window is at most 256, so K-1 fits 8 bits
	localparam int ERR_W  = 23;  // signed range of smoothed-minus-raw error handled exactly
	localparam int MAG_W  = 23;  // magnitude of that error, up to 2^22
	localparam int KM1_W  = 8;
	localparam int KDIV_W = 9;
	localparam int MUL_W  = 30;  // (K-1)*|err| stays below 2^30
	localparam int QUO_W  = 23;  // quotient magnitude, up to 2^22
	localparam int REM_W  = 10;  // partial remainder, below 2K

	// compute stages between accept and the output register
	localparam int PIPE_STAGES = 7;

	typedef enum logic [REASON_W-1:0] {
		REASON_NORMAL = 3'd0,
		REASON_NODATA = 3'd1,
		REASON_SKIP   = 3'd2,
		REASON_AGE    = 3'd3,
		REASON_SLIP   = 3'd4
	} reason_t;

	// load enables of the divider stages
	typedef struct packed {
		logic ld_s4;
		logic ld_s5;
		logic ld_s6;
		logic ld_s7;
	} csrf_ld_t;

endpackage

// ===== rtl/carrier_smoothed_range_filter_core.sv =====
// ----------------------------------------------------------------------------
// carrier_smoothed_range_filter_core
// Per-satellite Hatch filter. Each request carries one satellite measurement;
// the block reads that satellite's entry from a synchronous memory, runs it
// through seven compute stages and writes the updated entry back from the
// last one. Requests for different satellites are taken one per clock while
// the stages have room. A request for a satellite that is still in the
// compute stages is held off until that update has been written, so a
// stream on a single satellite is limited by the read-modify-write loop
// through the state memory. The output register lets a new request in while
// a result waits.
// Entry valid marks are flip-flops cleared by reset, so no clearing pass is
// needed. Division by the window rounds toward zero; out-of-range satellite
// numbers return the raw range with reason "no history" and touch no state.
// ----------------------------------------------------------------------------
`include "carrier_smoothed_range_filter_core_assert.svh"

module carrier_smoothed_range_filter_core #(
	parameter int NUM_SATS = csrf_pkg::NUM_SATS_DEF,
	parameter int WINDOW_K = csrf_pkg::WINDOW_K_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// measurement requests
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [csrf_pkg::SAT_INDEX_W-1:0]       sat_index,
	input  logic signed [csrf_pkg::RANGE_W-1:0]    code_range,
	input  logic signed [csrf_pkg::PHASE_W-1:0]    carrier_phase,
	input  logic [csrf_pkg::EPOCH_W-1:0]           epoch_time,
	// results
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [csrf_pkg::RANGE_W-1:0]    smoothed_range,
	output logic [csrf_pkg::REASON_W-1:0]          restart_reason,
	// configuration writes
	input  logic                                   cfg_we,
	input  logic [csrf_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [csrf_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import csrf_pkg::*;

	localparam int AW   = (NUM_SATS > 1) ? $clog2(NUM_SATS) : 1;
	localparam int IXW  = (AW > SAT_INDEX_W) ? AW : SAT_INDEX_W;
	localparam int NSTG = PIPE_STAGES;
	localparam int DIFF_W = QUO_W + 2;

	typedef struct packed {
		logic [RANGE_W-1:0] filt;
		logic [PHASE_W-1:0] phase;
		logic [EPOCH_W-1:0] prev;
		logic [EPOCH_W-1:0] start;
	} mem_word_t;

	typedef struct packed {
		logic [RANGE_W-1:0] range;
		logic [PHASE_W-1:0] phase;
		logic [EPOCH_W-1:0] epoch;
		logic [EPOCH_W-1:0] start;
		reason_t            reason;
		logic               big;
	} carry_t;

	// configuration registers
	logic [INTERVAL_W-1:0] epoch_interval_q;
	logic [TOL_W-1:0]      epoch_tolerance_q;
	logic [AGE_W-1:0]      max_age_q;
	logic [SLIP_W-1:0]     slip_threshold_q;

	// state store
	mem_word_t             state_mem_q [NUM_SATS];
	logic [NUM_SATS-1:0]   entry_valid_q;

	// pipeline control
	logic [NSTG:1]         stg_v_q;
	logic [NSTG:1]         take, free, leave;
	logic                  take_out;
	logic [AW-1:0]         tag_addr_q [1:NSTG];
	logic [NSTG:1]         tag_inr_q;
	logic                  hazard;
	logic                  in_fire;
	logic [IXW-1:0]        idx_ext;
	logic                  in_inrange;
	logic [AW-1:0]         in_addr;
	csrf_ld_t              div_ld;

	// stage 1
	mem_word_t             word_s1;
	logic [RANGE_W-1:0]    range_s1;
	logic [PHASE_W-1:0]    phase_s1;
	logic [EPOCH_W-1:0]    epoch_s1;
	logic                  vld_s1;

	// stage 2
	logic [RANGE_W-1:0]    range_s2;
	logic [PHASE_W-1:0]    phase_s2;
	logic [EPOCH_W-1:0]    epoch_s2;
	logic [EPOCH_W-1:0]    start_s2;
	logic                  vld_s2;
	logic signed [PHASE_W:0]   dphase_s2;
	logic signed [RANGE_W:0]   fr_s2;
	logic signed [EPOCH_W:0]   dt_s2;
	logic signed [EPOCH_W:0]   age_s2;
	logic [PHASE_W:0]      dphase_c;
	logic [RANGE_W:0]      fr_c;
	logic [EPOCH_W:0]      dt_c, age_c;

	// stage 3 inputs
	logic [PHASE_W+1:0]        e_c;
	logic signed [EPOCH_W+1:0] skip_x, tol_s, age_x, max_s;
	logic                      skip_c, old_c;
	carry_t                    side_c;
	logic signed [ERR_W-1:0]   e_s3;
	carry_t                    side_q [3:NSTG];

	// stage 7 from the divider
	logic signed [QUO_W:0]     quo_s7;
	logic                      neg_s7, rem_nz_s7;

	// final stage
	carry_t                    fin;
	logic signed [RANGE_W:0]   g, s_rnd, r41;
	logic signed [1:0]         adj;
	logic signed [DIFF_W-1:0]  diff, thr_s;
	logic                      slip, restart;
	logic [RANGE_W-1:0]        s_fin;
	reason_t                   reason_fin;
	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	mem_word_t                 wr_word;

	// output register
	logic                      out_valid_q;
	logic [RANGE_W-1:0]        res_range_q;
	reason_t                   res_reason_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_interval_q  <= EPOCH_INTERVAL_RST;
			epoch_tolerance_q <= EPOCH_TOLERANCE_RST;
			max_age_q         <= MAX_AGE_RST;
			slip_threshold_q  <= SLIP_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EPOCH_INTERVAL:  epoch_interval_q  <= cfg_wdata[INTERVAL_W-1:0];
				REG_EPOCH_TOLERANCE: epoch_tolerance_q <= cfg_wdata[TOL_W-1:0];
				REG_MAX_AGE:         max_age_q         <= cfg_wdata[AGE_W-1:0];
				REG_SLIP_THRESHOLD:  slip_threshold_q  <= cfg_wdata[SLIP_W-1:0];
				default: ;
			endcase
		end
	end

	// request decode
	assign idx_ext    = IXW'(sat_index);
	assign in_inrange = (32'(sat_index) < 32'(NUM_SATS));
	assign in_addr    = in_inrange ? idx_ext[AW-1:0] : '0;

	// interlock: same entry still between read and write-back
	always_comb begin
		hazard = 1'b0;
		for (int i = 1; i <= NSTG; i++) begin
			if (stg_v_q[i] && tag_inr_q[i] && in_inrange && (tag_addr_q[i] == in_addr))
				hazard = 1'b1;
		end
	end

	// stage flow: a stage is free when empty or when its contents move on
	always_comb begin
		take_out   = stg_v_q[NSTG] && (!out_valid_q || out_ready);
		free[NSTG] = !stg_v_q[NSTG] || take_out;
		for (int i = NSTG - 1; i >= 1; i--)
			free[i] = !stg_v_q[i] || free[i+1];
		in_ready = free[1] && !hazard;
		in_fire  = in_valid && in_ready;
		take[1]  = in_fire;
		for (int i = 2; i <= NSTG; i++)
			take[i] = stg_v_q[i-1] && free[i];
		for (int i = 1; i < NSTG; i++)
			leave[i] = take[i+1];
		leave[NSTG] = take_out;
	end

	assign div_ld = '{ld_s4: take[4], ld_s5: take[5], ld_s6: take[6], ld_s7: take[7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_v_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			for (int i = 1; i <= NSTG; i++) begin
				if (take[i])
					stg_v_q[i] <= 1'b1;
				else if (leave[i])
					stg_v_q[i] <= 1'b0;
			end
			if (take_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// entry tags follow the request down the pipe
	always_ff @(posedge clk) begin
		if (take[1]) begin
			tag_addr_q[1] <= in_addr;
			tag_inr_q[1]  <= in_inrange;
		end
		for (int i = 2; i <= NSTG; i++) begin
			if (take[i]) begin
				tag_addr_q[i] <= tag_addr_q[i-1];
				tag_inr_q[i]  <= tag_inr_q[i-1];
			end
		end
	end

	// valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			vld_s1        <= 1'b0;
		end else begin
			if (wr_en)
				entry_valid_q[wr_addr] <= 1'b1;
			if (in_fire)
				vld_s1 <= in_inrange && entry_valid_q[in_addr];
		end
	end

	// state memory: one read port at accept, one write port at the last stage
	always_ff @(posedge clk) begin
		if (in_fire)
			word_s1 <= state_mem_q[in_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			state_mem_q[wr_addr] <= wr_word;
	end

	// stage 1 capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			range_s1 <= code_range;
			phase_s1 <= carrier_phase;
			epoch_s1 <= epoch_time;
		end
	end

	// stage 2: phase step, filter offset and time differences
	assign dphase_c = {phase_s1[PHASE_W-1], phase_s1} - {word_s1.phase[PHASE_W-1], word_s1.phase};
	assign fr_c     = {word_s1.filt[RANGE_W-1], word_s1.filt} - {range_s1[RANGE_W-1], range_s1};
	assign dt_c     = {1'b0, epoch_s1} - {1'b0, word_s1.prev};
	assign age_c    = {1'b0, epoch_s1} - {1'b0, word_s1.start};

	always_ff @(posedge clk) begin
		if (take[2]) begin
			range_s2  <= range_s1;
			phase_s2  <= phase_s1;
			epoch_s2  <= epoch_s1;
			start_s2  <= word_s1.start;
			vld_s2    <= vld_s1;
			dphase_s2 <= $signed(dphase_c);
			fr_s2     <= $signed(fr_c);
			dt_s2     <= $signed(dt_c);
			age_s2    <= $signed(age_c);
		end
	end

	// stage 3: smoothing error, epoch gap and age checks
	always_comb begin
		e_c    = {dphase_s2[PHASE_W], dphase_s2} +
			{{(PHASE_W + 1 - RANGE_W){fr_s2[RANGE_W]}}, fr_s2};
		skip_x = $signed({dt_s2[EPOCH_W], dt_s2}) -
			$signed({{(EPOCH_W + 2 - INTERVAL_W){1'b0}}, epoch_interval_q});
		tol_s  = $signed({{(EPOCH_W + 2 - TOL_W){1'b0}}, epoch_tolerance_q});
		age_x  = $signed({age_s2[EPOCH_W], age_s2});
		max_s  = $signed({{(EPOCH_W + 2 - AGE_W){1'b0}}, max_age_q});
		skip_c = (skip_x > tol_s) || (skip_x < -tol_s);
		old_c  = (age_x > max_s) || (age_x < -max_s);

		side_c.range = range_s2;
		side_c.phase = phase_s2;
		side_c.epoch = epoch_s2;
		side_c.start = start_s2;
		// error too large for the exact path always sets the slip test
		side_c.big   = !((e_c[PHASE_W+1:ERR_W-1] == '0) || (e_c[PHASE_W+1:ERR_W-1] == '1));
		if (!vld_s2)
			side_c.reason = REASON_NODATA;
		else if (skip_c)
			side_c.reason = REASON_SKIP;
		else if (old_c)
			side_c.reason = REASON_AGE;
		else
			side_c.reason = REASON_NORMAL;
	end

	always_ff @(posedge clk) begin
		if (take[3]) begin
			side_q[3] <= side_c;
			e_s3      <= $signed(e_c[ERR_W-1:0]);
		end
		for (int i = 4; i <= NSTG; i++) begin
			if (take[i])
				side_q[i] <= side_q[i-1];
		end
	end

	// stages 4 to 7: divide by the window
	csrf_kdiv #(
		.WINDOW_K (WINDOW_K)
	) u_kdiv (
		.clk       (clk),
		.ctl       (div_ld),
		.err_s3    (e_s3),
		.quo_s7    (quo_s7),
		.neg_s7    (neg_s7),
		.rem_nz_s7 (rem_nz_s7)
	);

	// last stage: round toward zero, slip test, saturate, write back
	always_comb begin
		fin   = side_q[NSTG];
		r41   = $signed({fin.range[RANGE_W-1], fin.range});
		g     = r41 + $signed({{(RANGE_W - QUO_W){quo_s7[QUO_W]}}, quo_s7});
		adj   = 2'sd0;
		if (rem_nz_s7) begin
			if (neg_s7 && (g > 0))
				adj = -2'sd1;
			else if (!neg_s7 && (g < 0))
				adj = 2'sd1;
		end
		s_rnd = g + $signed({{(RANGE_W - 1){adj[1]}}, adj});
		diff  = $signed({quo_s7[QUO_W], quo_s7}) + $signed({{(DIFF_W - 2){adj[1]}}, adj});
		thr_s = $signed({{(DIFF_W - SLIP_W){1'b0}}, slip_threshold_q});
		slip  = fin.big || (diff > thr_s) || (diff < -thr_s);

		restart = (fin.reason != REASON_NORMAL) || slip;
		if (fin.reason != REASON_NORMAL)
			reason_fin = fin.reason;
		else if (slip)
			reason_fin = REASON_SLIP;
		else
			reason_fin = REASON_NORMAL;

		if (restart)
			s_fin = fin.range;
		else if (s_rnd[RANGE_W] != s_rnd[RANGE_W-1])
			s_fin = s_rnd[RANGE_W] ? {1'b1, {(RANGE_W - 1){1'b0}}} : {1'b0, {(RANGE_W - 1){1'b1}}};
		else
			s_fin = s_rnd[RANGE_W-1:0];

		wr_en         = take_out && tag_inr_q[NSTG];
		wr_addr       = tag_addr_q[NSTG];
		wr_word.filt  = s_fin;
		wr_word.phase = fin.phase;
		wr_word.prev  = fin.epoch;
		wr_word.start = restart ? fin.epoch : fin.start;
	end

	// output register
	always_ff @(posedge clk) begin
		if (take_out) begin
			res_range_q  <= s_fin;
			res_reason_q <= reason_fin;
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_range = $signed(res_range_q);
	assign restart_reason = res_reason_q;

	// checks
	`CSRF_ASSERT_SAME(a_no_rmw_overlap, wr_en && stg_v_q[1] && tag_inr_q[1], tag_addr_q[1] != wr_addr, "write-back hits an entry that is being read")
	`CSRF_ASSERT_NEXT(a_valid_after_write, wr_en, entry_valid_q[$past(wr_addr)], "entry not marked valid after write-back")
	`CSRF_ASSERT_SAME(a_normal_needs_entry, take_out && (reason_fin == REASON_NORMAL), tag_inr_q[NSTG], "normal result for a satellite without an entry")

endmodule

// ===== rtl/csrf_kdiv.sv =====
// ----------------------------------------------------------------------------
// csrf_kdiv
// Pipelined division of (K-1)*err by the window K, rounding toward zero, in
// four stages, using a reciprocal multiply with one correction step. Returns
// the signed quotient of the magnitude and whether the remainder is non-zero.
// ----------------------------------------------------------------------------
module csrf_kdiv #(
	parameter int WINDOW_K = csrf_pkg::WINDOW_K_DEF
) (
	input  logic                               clk,
	input  csrf_pkg::csrf_ld_t                 ctl,
	input  logic signed [csrf_pkg::ERR_W-1:0]  err_s3,
	output logic signed [csrf_pkg::QUO_W:0]    quo_s7,
	output logic                               neg_s7,
	output logic                               rem_nz_s7
);
	import csrf_pkg::*;

	localparam logic [KM1_W-1:0]  KM1   = KM1_W'(WINDOW_K - 1);
	localparam logic [KDIV_W-1:0] KV    = KDIV_W'(WINDOW_K);
	localparam logic [MUL_W-1:0]  RECIP = MUL_W'((64'd1 << MUL_W) / 64'(WINDOW_K));

	logic [MAG_W-1:0]         mag;
	logic [KM1_W+MAG_W-1:0]   m_full;
	logic [MUL_W-1:0]         m_s4, m_s5, m_s6;
	logic                     neg_s4, neg_s5, neg_s6;
	logic [2*MUL_W-1:0]       p_s5;
	logic [QUO_W-1:0]         qe;
	logic [QUO_W+KDIV_W-1:0]  qk;
	logic [MUL_W-1:0]         r0_full;
	logic [QUO_W-1:0]         qe_s6;
	logic [REM_W-1:0]         r0_s6;
	logic [QUO_W-1:0]         q_fix;
	logic [REM_W-1:0]         r_fix;

	// stage 4: magnitude times K-1
	assign mag    = err_s3[ERR_W-1] ? MAG_W'(-err_s3) : MAG_W'(err_s3);
	assign m_full = KM1 * mag;

	// stage 6 inputs: estimated quotient and partial remainder
	assign qe      = p_s5[MUL_W +: QUO_W];
	assign qk      = qe * KV;
	assign r0_full = m_s5 - qk[MUL_W-1:0];

	// stage 7 inputs: estimate is low by at most one
	always_comb begin
		if (r0_s6 >= REM_W'(KV)) begin
			q_fix = qe_s6 + QUO_W'(1);
			r_fix = r0_s6 - REM_W'(KV);
		end else begin
			q_fix = qe_s6;
			r_fix = r0_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			m_s4   <= m_full[MUL_W-1:0];
			neg_s4 <= err_s3[ERR_W-1];
		end
		if (ctl.ld_s5) begin
			p_s5   <= m_s4 * RECIP;
			m_s5   <= m_s4;
			neg_s5 <= neg_s4;
		end
		if (ctl.ld_s6) begin
			qe_s6  <= qe;
			r0_s6  <= r0_full[REM_W-1:0];
			m_s6   <= m_s5;
			neg_s6 <= neg_s5;
		end
		if (ctl.ld_s7) begin
			quo_s7    <= neg_s6 ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
			neg_s7    <= neg_s6 && (m_s6 != '0);
			rem_nz_s7 <= (r_fix != '0);
		end
	end

endmodule
